### hdl/assert_macros.svh
// Assertion macros shared by the S-expression parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define SEXP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define SEXP_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SEXP_ASSERT(lbl, clk, rst, prop, msg)
`define SEXP_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### hdl/sexp_pkg.sv
// Shared types and constants of the S-expression event parser.
`default_nettype none
package sexp_pkg;

  // Default counter widths.
  localparam int LINE_WIDTH_DEFAULT   = 16;
  localparam int COLUMN_WIDTH_DEFAULT = 16;

  // Reported counters are capped to this width.
  localparam int REPORT_WIDTH = 16;
  localparam logic [REPORT_WIDTH-1:0] REPORT_MAX = '1;

  // Most events one input beat can cause, and the bundle queue depth.
  localparam int MAX_EVENTS  = 3;
  localparam int QUEUE_DEPTH = 2;

  // Input actions.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_EOS  = 1'b1;

  // Event kinds.
  localparam logic [2:0] EV_DOC_START  = 3'd0;
  localparam logic [2:0] EV_TOKEN_CHAR = 3'd1;
  localparam logic [2:0] EV_ELEM_START = 3'd2;
  localparam logic [2:0] EV_ELEM_END   = 3'd3;
  localparam logic [2:0] EV_DOC_END    = 3'd4;
  localparam logic [2:0] EV_ERROR      = 3'd5;

  // Error codes.
  localparam logic ERR_BRACE_NO_TOKEN = 1'b0;
  localparam logic ERR_AFTER_CLOSE    = 1'b1;

  // Characters with a meaning of their own.
  localparam logic [7:0] CHAR_LPAREN = 8'h28;
  localparam logic [7:0] CHAR_RPAREN = 8'h29;
  localparam logic [7:0] CHAR_SEMI   = 8'h3B;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_TAB    = 8'h09;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;

  // One input beat.
  typedef struct packed {
    logic       action;
    logic [7:0] byte_value;
  } in_beat_t;

  // One output beat.
  typedef struct packed {
    logic [2:0]              event_kind;
    logic [7:0]              char_value;
    logic                    starts_token;
    logic                    error_code;
    logic [REPORT_WIDTH-1:0] line_number;
    logic [REPORT_WIDTH-1:0] column_number;
    logic                    last;
  } out_beat_t;

  // One event inside the parser, before the last flag is known.
  typedef struct packed {
    logic [2:0]              event_kind;
    logic [7:0]              char_value;
    logic                    starts_token;
    logic                    error_code;
    logic [REPORT_WIDTH-1:0] line_number;
    logic [REPORT_WIDTH-1:0] column_number;
  } event_t;

  // All events caused by one input beat.
  typedef struct packed {
    logic [1:0]                  count;
    event_t [MAX_EVENTS-1:0]     events;
  } bundle_t;

endpackage
`default_nettype wire

### hdl/sexpr_token_event_parser_unit.sv
// Top level of the streaming S-expression event parser.
// Usage:
//   The text channel (text_valid/text_ready/text_data) takes one beat per
//   cycle: a byte of text or an end-of-stream mark. The event channel
//   (evt_valid/evt_ready/evt_data) delivers the events each beat causes, in
//   order, one event per cycle while evt_ready is high, with last set on the
//   final event of a beat. A beat causes zero to three events.
//   The first event of a beat reaches the event port after its bundle has
//   passed through a queue slot and the serializer's current-bundle register.
//   A beat is taken every cycle while the two-entry bundle queue has room;
//   a beat's events go out on the event port one at a time, so the sustained
//   rate is one beat per cycle when beats average at most one event. Beats
//   that cause no event never reach the queue. Reset puts the scanner in idle
//   with counters cleared and empties the queue and output stage; the next
//   beat opens a document. When the receiver stalls, the output stage holds
//   its event and the queue fills; text_ready drops once the queue is full and
//   rises as soon as a bundle leaves it.
`default_nettype none
module sexpr_token_event_parser_unit #(
  parameter int LINE_WIDTH   = sexp_pkg::LINE_WIDTH_DEFAULT,
  parameter int COLUMN_WIDTH = sexp_pkg::COLUMN_WIDTH_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                text_valid,
  output logic                     text_ready,
  input  wire sexp_pkg::in_beat_t  text_data,
  output logic                     evt_valid,
  input  wire logic                evt_ready,
  output sexp_pkg::out_beat_t      evt_data
);

  logic              push_valid;
  logic              push_ready;
  sexp_pkg::bundle_t push_data;
  logic              pop_valid;
  logic              pop_ready;
  sexp_pkg::bundle_t pop_data;

  // Scanner front end.
  sexp_front #(
    .LINE_WIDTH   (LINE_WIDTH),
    .COLUMN_WIDTH (COLUMN_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_data  (text_data),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Decoupling queue.
  sexp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Event serializer.
  sexp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt_data  (evt_data)
  );

endmodule
`default_nettype wire

### hdl/sexp_front.sv
// Front end: accepts input beats, runs the scanner state and builds event bundles.
`default_nettype none
module sexp_front #(
  parameter int LINE_WIDTH   = sexp_pkg::LINE_WIDTH_DEFAULT,
  parameter int COLUMN_WIDTH = sexp_pkg::COLUMN_WIDTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               text_valid,
  output logic                    text_ready,
  input  wire sexp_pkg::in_beat_t text_data,
  input  wire logic               push_ready,
  output logic                    push_valid,
  output sexp_pkg::bundle_t       push_data
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_TEXT    = 2'd1;
  localparam logic [1:0] MODE_SEMI    = 2'd2;
  localparam logic [1:0] MODE_COMMENT = 2'd3;

  localparam int LX = (LINE_WIDTH > sexp_pkg::REPORT_WIDTH) ?
                      LINE_WIDTH : sexp_pkg::REPORT_WIDTH;
  localparam int CX = (COLUMN_WIDTH > sexp_pkg::REPORT_WIDTH) ?
                      COLUMN_WIDTH : sexp_pkg::REPORT_WIDTH;

  logic [1:0]              scan_mode, scan_mode_next;
  logic                    new_token_flag, new_token_flag_next;
  logic                    allow_token_flag, allow_token_flag_next;
  logic                    tokens_pending, tokens_pending_next;
  logic [LINE_WIDTH-1:0]   line_count, line_count_next;
  logic [COLUMN_WIDTH-1:0] column_count, column_count_next;

  logic                    accept;
  logic                    do_text;
  logic [1:0]              n_events;
  sexp_pkg::event_t [sexp_pkg::MAX_EVENTS-1:0] events;

  // Counters are reported capped at the report width.
  function automatic logic [sexp_pkg::REPORT_WIDTH-1:0] cap_line(
    input logic [LINE_WIDTH-1:0] v
  );
    logic [LX-1:0] x;
    x = LX'(v);
    cap_line = (x > LX'(sexp_pkg::REPORT_MAX)) ? sexp_pkg::REPORT_MAX :
               x[sexp_pkg::REPORT_WIDTH-1:0];
  endfunction

  function automatic logic [sexp_pkg::REPORT_WIDTH-1:0] cap_column(
    input logic [COLUMN_WIDTH-1:0] v
  );
    logic [CX-1:0] x;
    x = CX'(v);
    cap_column = (x > CX'(sexp_pkg::REPORT_MAX)) ? sexp_pkg::REPORT_MAX :
                 x[sexp_pkg::REPORT_WIDTH-1:0];
  endfunction

  function automatic sexp_pkg::event_t mk_event(
    input logic [2:0]              kind,
    input logic [7:0]              ch,
    input logic                    st,
    input logic                    err,
    input logic [LINE_WIDTH-1:0]   ln,
    input logic [COLUMN_WIDTH-1:0] cn
  );
    sexp_pkg::event_t e;
    e.event_kind    = kind;
    e.char_value    = ch;
    e.starts_token  = st;
    e.error_code    = err;
    e.line_number   = cap_line(ln);
    e.column_number = cap_column(cn);
    mk_event = e;
  endfunction

  assign text_ready = push_ready;
  assign accept     = text_valid && push_ready;

  // Scanner: all events of one beat and the state it leaves behind.
  always_comb begin
    scan_mode_next        = scan_mode;
    new_token_flag_next   = new_token_flag;
    allow_token_flag_next = allow_token_flag;
    tokens_pending_next   = tokens_pending;
    line_count_next       = line_count;
    column_count_next     = column_count;
    n_events              = 2'd0;
    events                = '0;
    do_text               = 1'b0;

    // A beat in idle opens a new document.
    if (scan_mode == MODE_IDLE) begin
      line_count_next       = '0;
      column_count_next     = '0;
      new_token_flag_next   = 1'b1;
      allow_token_flag_next = 1'b0;
      tokens_pending_next   = 1'b0;
      events[n_events] = mk_event(sexp_pkg::EV_DOC_START, 8'h00, 1'b0, 1'b0,
                                  line_count_next, column_count_next);
      n_events = n_events + 2'd1;
      scan_mode_next = MODE_TEXT;
    end

    if (text_data.action == sexp_pkg::ACT_EOS) begin
      column_count_next = (&column_count_next) ? column_count_next :
                          column_count_next + 1'b1;
      events[n_events] = mk_event(sexp_pkg::EV_DOC_END, 8'h00, 1'b0, 1'b0,
                                  line_count_next, column_count_next);
      n_events = n_events + 2'd1;
      scan_mode_next = MODE_IDLE;
    end else if (scan_mode_next == MODE_SEMI) begin
      if (text_data.byte_value == sexp_pkg::CHAR_SEMI) begin
        scan_mode_next = MODE_COMMENT;
      end else begin
        // The held semicolon is a token character of its own, or an error where no token is allowed.
        scan_mode_next = MODE_TEXT;
        if (!allow_token_flag_next) begin
          events[n_events] = mk_event(sexp_pkg::EV_ERROR, 8'h00, 1'b0,
                                      sexp_pkg::ERR_AFTER_CLOSE,
                                      line_count_next, column_count_next);
          n_events = n_events + 2'd1;
          scan_mode_next = MODE_IDLE;
        end else begin
          events[n_events] = mk_event(sexp_pkg::EV_TOKEN_CHAR, sexp_pkg::CHAR_SEMI,
                                      new_token_flag_next, 1'b0,
                                      line_count_next, column_count_next);
          n_events = n_events + 2'd1;
          new_token_flag_next = 1'b0;
          tokens_pending_next = 1'b1;
          do_text = 1'b1;
        end
      end
    end else if (scan_mode_next == MODE_COMMENT) begin
      if (text_data.byte_value == sexp_pkg::CHAR_LF ||
          text_data.byte_value == sexp_pkg::CHAR_CR) begin
        scan_mode_next = MODE_TEXT;
        do_text = 1'b1;
      end
    end else begin
      do_text = 1'b1;
    end

    // Ordinary text handling of the byte.
    if (do_text) begin
      column_count_next = (&column_count_next) ? column_count_next :
                          column_count_next + 1'b1;
      case (text_data.byte_value)
        sexp_pkg::CHAR_LPAREN: begin
          if (allow_token_flag_next && !tokens_pending_next) begin
            events[n_events] = mk_event(sexp_pkg::EV_ERROR, 8'h00, 1'b0,
                                        sexp_pkg::ERR_BRACE_NO_TOKEN,
                                        line_count_next, column_count_next);
            n_events = n_events + 2'd1;
            scan_mode_next = MODE_IDLE;
          end else begin
            if (allow_token_flag_next) begin
              events[n_events] = mk_event(sexp_pkg::EV_ELEM_START, 8'h00, 1'b0, 1'b0,
                                          line_count_next, column_count_next);
              n_events = n_events + 2'd1;
              tokens_pending_next = 1'b0;
            end
            new_token_flag_next   = 1'b1;
            allow_token_flag_next = 1'b1;
          end
        end
        sexp_pkg::CHAR_RPAREN: begin
          if (tokens_pending_next) begin
            events[n_events] = mk_event(sexp_pkg::EV_ELEM_START, 8'h00, 1'b0, 1'b0,
                                        line_count_next, column_count_next);
            n_events = n_events + 2'd1;
            tokens_pending_next = 1'b0;
          end
          events[n_events] = mk_event(sexp_pkg::EV_ELEM_END, 8'h00, 1'b0, 1'b0,
                                      line_count_next, column_count_next);
          n_events = n_events + 2'd1;
          new_token_flag_next   = 1'b1;
          allow_token_flag_next = 1'b0;
        end
        sexp_pkg::CHAR_LF: begin
          line_count_next = (&line_count_next) ? line_count_next :
                            line_count_next + 1'b1;
          column_count_next   = '0;
          new_token_flag_next = 1'b1;
        end
        sexp_pkg::CHAR_CR: begin
          column_count_next   = '0;
          new_token_flag_next = 1'b1;
        end
        sexp_pkg::CHAR_SPACE, sexp_pkg::CHAR_TAB: begin
          new_token_flag_next = 1'b1;
        end
        sexp_pkg::CHAR_SEMI: begin
          scan_mode_next = MODE_SEMI;
        end
        default: begin
          if (!allow_token_flag_next) begin
            events[n_events] = mk_event(sexp_pkg::EV_ERROR, 8'h00, 1'b0,
                                        sexp_pkg::ERR_AFTER_CLOSE,
                                        line_count_next, column_count_next);
            n_events = n_events + 2'd1;
            scan_mode_next = MODE_IDLE;
          end else begin
            events[n_events] = mk_event(sexp_pkg::EV_TOKEN_CHAR,
                                        text_data.byte_value,
                                        new_token_flag_next, 1'b0,
                                        line_count_next, column_count_next);
            n_events = n_events + 2'd1;
            new_token_flag_next = 1'b0;
            tokens_pending_next = 1'b1;
          end
        end
      endcase
    end
  end

  // Beats that cause no event are absorbed here.
  assign push_valid       = accept && (n_events != 2'd0);
  assign push_data.count  = n_events;
  assign push_data.events = events;

  // Scanner state.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode        <= MODE_IDLE;
      new_token_flag   <= 1'b1;
      allow_token_flag <= 1'b0;
      tokens_pending   <= 1'b0;
      line_count       <= '0;
      column_count     <= '0;
    end else if (accept) begin
      scan_mode        <= scan_mode_next;
      new_token_flag   <= new_token_flag_next;
      allow_token_flag <= allow_token_flag_next;
      tokens_pending   <= tokens_pending_next;
      line_count       <= line_count_next;
      column_count     <= column_count_next;
    end
  end

endmodule
`default_nettype wire

### hdl/sexp_queue.sv
// Short bundle queue between the scanner and the event serializer.
`default_nettype none
`include "assert_macros.svh"
module sexp_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire sexp_pkg::bundle_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output sexp_pkg::bundle_t      pop_data
);

  localparam int DEPTH = sexp_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  sexp_pkg::bundle_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign push_ready = (fill != CW'(DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Every stored bundle carries at least one event.
  `SEXP_ASSERT_NEVER(a_push_empty_bundle, clk, rst, do_push && (push_data.count == 2'd0), "empty bundle queued")
  // Fill level tracks the handshakes.
  `SEXP_ASSERT(a_fill_track, clk, rst, (do_push && !do_pop) |=> (fill == $past(fill) + 1'b1), "fill level lost a push")

endmodule
`default_nettype wire

### hdl/sexp_back.sv
// Back end: serializes event bundles into output beats, one event per cycle while evt_ready is high.
`default_nettype none
`include "assert_macros.svh"
module sexp_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pop_valid,
  output logic                   pop_ready,
  input  wire sexp_pkg::bundle_t pop_data,
  output logic                   evt_valid,
  input  wire logic              evt_ready,
  output sexp_pkg::out_beat_t    evt_data
);

  sexp_pkg::bundle_t cur;
  logic              busy;
  logic [1:0]        idx;
  logic              is_last;
  sexp_pkg::event_t  ev;

  assign ev      = cur.events[idx];
  assign is_last = (idx == cur.count - 2'd1);

  assign evt_valid              = busy;
  assign evt_data.event_kind    = ev.event_kind;
  assign evt_data.char_value    = ev.char_value;
  assign evt_data.starts_token  = ev.starts_token;
  assign evt_data.error_code    = ev.error_code;
  assign evt_data.line_number   = ev.line_number;
  assign evt_data.column_number = ev.column_number;
  assign evt_data.last          = is_last;

  // Take the next bundle once the current one has gone out.
  assign pop_ready = !busy || (evt_ready && is_last);

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      cur <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (pop_valid && pop_ready) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && evt_ready) begin
      if (is_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // The index stays inside the bundle it walks.
  `SEXP_ASSERT(a_idx_in_range, clk, rst, busy |-> (idx < cur.count), "event index beyond bundle")
  // A held bundle is never empty.
  `SEXP_ASSERT_NEVER(a_empty_cur, clk, rst, busy && (cur.count == 2'd0), "empty bundle held")
  // After the last beat goes out with nothing queued, the output drains.
  `SEXP_ASSERT(a_drain, clk, rst, (busy && evt_ready && is_last && !pop_valid) |=> !busy, "output did not drain")

endmodule
`default_nettype wire
